// ===== rtl/core/dsd_pkg.sv =====
// Package for the dual-key SipHash-2-4 digest block: word and job types,
// SipHash constants, key reset values and the round/absorb/init functions.
// Depends on nothing; every rtl/core module imports it.
package dsd_pkg;

   localparam int WORD_W      = 64;
   localparam int BYTES_W     = 4;
   localparam int LEN_W       = 8;
   localparam int BYTE_W      = 8;
   localparam int WORD_BYTES  = 8;

   localparam logic [WORD_W-1:0] SIP_C0 = 64'h736f6d6570736575;
   localparam logic [WORD_W-1:0] SIP_C1 = 64'h646f72616e646f6d;
   localparam logic [WORD_W-1:0] SIP_C2 = 64'h6c7967656e657261;
   localparam logic [WORD_W-1:0] SIP_C3 = 64'h7465646279746573;
   localparam logic [WORD_W-1:0] FINAL_XOR = 64'h00000000000000ff;

   localparam logic [WORD_W-1:0] KEY_A_LOW_RST  = 64'h0706050403020100;
   localparam logic [WORD_W-1:0] KEY_A_HIGH_RST = 64'h0f0e0d0c0b0a0908;
   localparam logic [WORD_W-1:0] KEY_B_LOW_RST  = 64'h1716151413121110;
   localparam logic [WORD_W-1:0] KEY_B_HIGH_RST = 64'h1f1e1d1c1b1a1918;

   localparam int ROT_V1   = 13;
   localparam int ROT_V3_A = 16;
   localparam int ROT_V3_B = 21;
   localparam int ROT_V1_B = 17;
   localparam int ROT_HALF = 32;

   localparam logic [BYTES_W-1:0] FULL_BYTES = 4'd8;

   // link queue between front and back
   localparam int LINK_DEPTH = 2;
   localparam int LINK_PTR_W = $clog2(LINK_DEPTH);
   localparam int LINK_CNT_W = LINK_PTR_W + 1;

   // result queue
   localparam int OUT_DEPTH = 8;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W = OUT_PTR_W + 1;

   typedef enum logic [1:0] {
      CSR_KEY_A_LOW  = 2'd0,
      CSR_KEY_A_HIGH = 2'd1,
      CSR_KEY_B_LOW  = 2'd2,
      CSR_KEY_B_HIGH = 2'd3
   } csr_index_type;

   typedef logic [3:0][WORD_W-1:0] lane_type;

   typedef struct packed {
      logic [WORD_W-1:0]  data_word;
      logic [BYTES_W-1:0] byte_count;
      logic               last;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] digest_low;
      logic [WORD_W-1:0] digest_high;
   } rsp_type;

   typedef struct packed {
      lane_type          lane_a;
      lane_type          lane_b;
      logic [WORD_W-1:0] tail;
   } job_type;

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                              input int s);
      return (x << s) | (x >> (WORD_W - s));
   endfunction

   function automatic lane_type sip_round(input lane_type v);
      lane_type r;
      r = v;
      r[0] = r[0] + r[1]; r[1] = rotl(r[1], ROT_V1);   r[1] = r[1] ^ r[0];
      r[0] = rotl(r[0], ROT_HALF);
      r[2] = r[2] + r[3]; r[3] = rotl(r[3], ROT_V3_A); r[3] = r[3] ^ r[2];
      r[0] = r[0] + r[3]; r[3] = rotl(r[3], ROT_V3_B); r[3] = r[3] ^ r[0];
      r[2] = r[2] + r[1]; r[1] = rotl(r[1], ROT_V1_B); r[1] = r[1] ^ r[2];
      r[2] = rotl(r[2], ROT_HALF);
      return r;
   endfunction

   // two compression rounds around one message word
   function automatic lane_type sip_absorb(input lane_type v, input logic [WORD_W-1:0] m);
      lane_type r;
      r    = v;
      r[3] = r[3] ^ m;
      r    = sip_round(sip_round(r));
      r[0] = r[0] ^ m;
      return r;
   endfunction

   function automatic lane_type sip_init(input logic [WORD_W-1:0] k0,
                                         input logic [WORD_W-1:0] k1);
      lane_type r;
      r[0] = SIP_C0 ^ k0;
      r[1] = SIP_C1 ^ k1;
      r[2] = SIP_C2 ^ k0;
      r[3] = SIP_C3 ^ k1;
      return r;
   endfunction

endpackage

// ===== rtl/core/dsd_front.sv =====
// Front part: key registers, chaining state of both lanes and the message length.
// Absorbs full words and hands each finished message to the back as a job.
// Depends on dsd_pkg.
module dsd_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  dsd_pkg::csr_index_type      csr_index,
   input  logic [dsd_pkg::WORD_W-1:0]  csr_data,
   input  logic                        req_accept,
   input  dsd_pkg::req_type            req_word,
   output logic                        job_push,
   output dsd_pkg::job_type            job
);
   import dsd_pkg::*;

   logic [WORD_W-1:0] key_a_low_ff, key_a_high_ff, key_b_low_ff, key_b_high_ff;
   lane_type          lane_a_ff, lane_b_ff, lane_a_in, lane_b_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              busy_ff, busy_in;

   lane_type          cur_a, cur_b, abs_a, abs_b;
   logic [LEN_W-1:0]  len_cur, len_next;
   logic [BYTES_W-1:0] n_eff;
   logic              full_word, ends;
   logic [WORD_W-1:0] kept;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_a_low_ff  <= KEY_A_LOW_RST;
         key_a_high_ff <= KEY_A_HIGH_RST;
         key_b_low_ff  <= KEY_B_LOW_RST;
         key_b_high_ff <= KEY_B_HIGH_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_KEY_A_LOW:  key_a_low_ff  <= csr_data;
            CSR_KEY_A_HIGH: key_a_high_ff <= csr_data;
            CSR_KEY_B_LOW:  key_b_low_ff  <= csr_data;
            CSR_KEY_B_HIGH: key_b_high_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      // outside a message the lanes are the key-derived initial state
      cur_a     = busy_ff ? lane_a_ff : sip_init(key_a_low_ff, key_a_high_ff);
      cur_b     = busy_ff ? lane_b_ff : sip_init(key_b_low_ff, key_b_high_ff);
      len_cur   = busy_ff ? len_ff : '0;
      full_word = req_word.byte_count[BYTES_W-1];
      n_eff     = full_word ? FULL_BYTES : req_word.byte_count;
      len_next  = len_cur + LEN_W'(n_eff);
      ends      = !full_word || req_word.last;
      abs_a     = sip_absorb(cur_a, req_word.data_word);
      abs_b     = sip_absorb(cur_b, req_word.data_word);

      for (int i = 0; i < WORD_BYTES; i++) begin
         kept[i*BYTE_W +: BYTE_W] = (BYTES_W'(i) < n_eff) ?
                                    req_word.data_word[i*BYTE_W +: BYTE_W] : '0;
      end

      job.lane_a = full_word ? abs_a : cur_a;
      job.lane_b = full_word ? abs_b : cur_b;
      job.tail   = {len_next,
                    (full_word ? {(WORD_W-LEN_W){1'b0}} : kept[WORD_W-LEN_W-1:0])};
      job_push   = req_accept && ends;

      lane_a_in = lane_a_ff;
      lane_b_in = lane_b_ff;
      len_in    = len_ff;
      busy_in   = busy_ff;
      if (req_accept) begin
         lane_a_in = abs_a;
         lane_b_in = abs_b;
         len_in    = len_next;
         busy_in   = !ends;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      lane_a_ff <= lane_a_in;
      lane_b_ff <= lane_b_in;
      len_ff    <= len_in;
   end

endmodule

// ===== rtl/core/dsd_link_queue.sv =====
// Short job queue between front and back, register based.
// Depends on dsd_pkg.
module dsd_link_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dsd_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output dsd_pkg::job_type head
);
   import dsd_pkg::*;

   job_type                 entry_ff [LINK_DEPTH];
   logic [LINK_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [LINK_CNT_W-1:0]   count_ff, count_in;
   logic                    do_push, do_pop;

   assign full    = (count_ff == LINK_CNT_W'(LINK_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + LINK_CNT_W'(do_push) - LINK_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/core/dsd_back.sv =====
// Back part: tail absorb and finalization pipeline, then the result queue.
// Depends on dsd_pkg.
module dsd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  dsd_pkg::job_type job_head,
   output logic             job_pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output dsd_pkg::rsp_type rsp_word
);
   import dsd_pkg::*;

   lane_type               s1_a_ff, s1_b_ff, s1_a_in, s1_b_in;
   lane_type               s2_a_ff, s2_b_ff, s2_a_in, s2_b_in;
   lane_type               fin_a, fin_b;
   logic                   s1_valid_ff, s2_valid_ff;
   rsp_type                fin_word;

   rsp_type                out_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [OUT_CNT_W-1:0]   count_ff, count_in;
   logic [OUT_CNT_W:0]     committed;
   logic                   out_pop;

   // take a job only when the result queue has room for everything in flight
   assign committed = (OUT_CNT_W+1)'(count_ff) + (OUT_CNT_W+1)'(s1_valid_ff)
                    + (OUT_CNT_W+1)'(s2_valid_ff);
   assign job_pop   = job_valid && (committed < (OUT_CNT_W+1)'(OUT_DEPTH));
   assign rsp_empty = (count_ff == '0);
   assign rsp_word  = out_ff[rd_ptr_ff];
   assign out_pop   = rsp_pop && !rsp_empty;

   always_comb begin
      s1_a_in    = sip_absorb(job_head.lane_a, job_head.tail);
      s1_b_in    = sip_absorb(job_head.lane_b, job_head.tail);
      s1_a_in[2] = s1_a_in[2] ^ FINAL_XOR;
      s1_b_in[2] = s1_b_in[2] ^ FINAL_XOR;
      s2_a_in    = sip_round(sip_round(s1_a_ff));
      s2_b_in    = sip_round(sip_round(s1_b_ff));
      fin_a      = sip_round(sip_round(s2_a_ff));
      fin_b      = sip_round(sip_round(s2_b_ff));
      fin_word.digest_low  = fin_a[0] ^ fin_a[1] ^ fin_a[2] ^ fin_a[3];
      fin_word.digest_high = fin_b[0] ^ fin_b[1] ^ fin_b[2] ^ fin_b[3];
      count_in = count_ff + OUT_CNT_W'(s2_valid_ff) - OUT_CNT_W'(out_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         s1_valid_ff <= job_pop;
         s2_valid_ff <= s1_valid_ff;
         wr_ptr_ff   <= wr_ptr_ff + OUT_PTR_W'(s2_valid_ff);
         rd_ptr_ff   <= rd_ptr_ff + OUT_PTR_W'(out_pop);
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_a_ff <= s1_a_in;
      s1_b_ff <= s1_b_in;
      s2_a_ff <= s2_a_in;
      s2_b_ff <= s2_b_in;
      if (s2_valid_ff) begin
         out_ff[wr_ptr_ff] <= fin_word;
      end
   end

endmodule

// ===== rtl/core/dual_siphash_digest.sv =====
// Dual-key SipHash-2-4 digest: one 64-bit message word accepted per cycle while the
// link queue is not full. A word that ends a message is absorbed in the front, queued
// in the link queue, then passes the tail absorb stage and two finalization stages;
// throughput up to one digest per cycle, set by the front's two-round compression loop.
// Reset (synchronous, active high): keys take their default values, lanes start fresh,
// both queues empty. Depends on dsd_pkg, dsd_front, dsd_link_queue, dsd_back.
module dual_siphash_digest (
   input  logic                        clock,
   input  logic                        reset,
   // configuration write channel
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  dsd_pkg::csr_index_type      csr_index,
   input  logic [dsd_pkg::WORD_W-1:0]  csr_data,
   // message words
   input  logic                        req_push,
   output logic                        req_full,
   input  dsd_pkg::req_type            req_word,
   // digests
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output dsd_pkg::rsp_type            rsp_word
);
   import dsd_pkg::*;

   logic    req_accept;
   logic    job_push, job_pop, link_full, link_empty;
   job_type job_new, job_head;

   // Hold off new words while the link queue is full: any word may end a
   // message and must find room for its job.
   assign req_full   = link_full;
   assign req_accept = req_push && !req_full;

   // Front: absorb full words into both lanes, track length, emit a job
   // (lanes plus padded tail) for every word that ends a message.
   dsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_accept (req_accept),
      .req_word   (req_word),
      .job_push   (job_push),
      .job        (job_new)
   );

   // Link queue: decouple the front from finalization stalls.
   dsd_link_queue u_link (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job_new),
      .full     (link_full),
      .pop      (job_pop),
      .empty    (link_empty),
      .head     (job_head)
   );

   // Back: absorb tail, finalize both lanes, queue digests for the consumer.
   dsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (!link_empty),
      .job_head  (job_head),
      .job_pop   (job_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_word  (rsp_word)
   );

endmodule

// ===== tb/sv/dsd_digest_checker.sv =====
// Scoreboard for the dual-key SipHash-2-4 digest block: watches the key, word and
// digest channels, predicts each digest and compares it with what pops out.
// Depends on dsd_pkg for the channel types, key indexes and key reset values.
module dsd_digest_checker
   import dsd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  csr_index_type     csr_index,
   input  logic [WORD_W-1:0] csr_data,
   input  logic              req_push,
   input  logic              req_full,
   input  req_type           req_word,
   input  logic              rsp_empty,
   input  logic              rsp_pop,
   input  rsp_type           rsp_word,
   output int                fail_count,
   output int                digests_pending,
   output int                digests_checked
);

   typedef logic [3:0][WORD_W-1:0] sip_state_type;

   logic [WORD_W-1:0] key_a_lo, key_a_hi, key_b_lo, key_b_hi;
   sip_state_type     lane_a, lane_b;
   logic [LEN_W-1:0]  msg_len;
   bit                mid_message;
   rsp_type           digest_queue[$];
   rsp_type           head;
   int                mismatches = 0;
   int                checked = 0;

   assign fail_count      = mismatches;
   assign digests_checked = checked;

   function automatic logic [WORD_W-1:0] rol(input logic [WORD_W-1:0] x,
                                             input int unsigned s);
      return (x << s) | (x >> (WORD_W - s));
   endfunction

   function automatic sip_state_type sip_mix(input sip_state_type v);
      sip_state_type w;
      w = v;
      w[0] = w[0] + w[1]; w[1] = rol(w[1], 13) ^ w[0]; w[0] = rol(w[0], 32);
      w[2] = w[2] + w[3]; w[3] = rol(w[3], 16) ^ w[2];
      w[0] = w[0] + w[3]; w[3] = rol(w[3], 21) ^ w[0];
      w[2] = w[2] + w[1]; w[1] = rol(w[1], 17) ^ w[2]; w[2] = rol(w[2], 32);
      return w;
   endfunction

   function automatic sip_state_type sip_compress(input sip_state_type v,
                                                  input logic [WORD_W-1:0] m);
      sip_state_type w;
      w    = v;
      w[3] = w[3] ^ m;
      w    = sip_mix(sip_mix(w));
      w[0] = w[0] ^ m;
      return w;
   endfunction

   function automatic logic [WORD_W-1:0] sip_finish(input sip_state_type v);
      sip_state_type w;
      w    = v;
      w[2] = w[2] ^ 64'hff;
      w    = sip_mix(sip_mix(sip_mix(sip_mix(w))));
      return w[0] ^ w[1] ^ w[2] ^ w[3];
   endfunction

   function automatic sip_state_type sip_load(input logic [WORD_W-1:0] k0,
                                              input logic [WORD_W-1:0] k1);
      sip_state_type w;
      w[0] = 64'h736f6d6570736575 ^ k0;
      w[1] = 64'h646f72616e646f6d ^ k1;
      w[2] = 64'h6c7967656e657261 ^ k0;
      w[3] = 64'h7465646279746573 ^ k1;
      return w;
   endfunction

   function automatic void reload_lanes();
      lane_a      = sip_load(key_a_lo, key_a_hi);
      lane_b      = sip_load(key_b_lo, key_b_hi);
      msg_len     = '0;
      mid_message = 1'b0;
   endfunction

   // fold one message word into both lanes; queue a digest when the message ends
   function automatic void absorb_word(input req_type w);
      logic [BYTES_W-1:0] n;
      logic [WORD_W-1:0]  tail;
      rsp_type            d;
      n = (w.byte_count > FULL_BYTES) ? FULL_BYTES : w.byte_count;
      if (n == FULL_BYTES) begin
         lane_a      = sip_compress(lane_a, w.data_word);
         lane_b      = sip_compress(lane_b, w.data_word);
         msg_len     = msg_len + LEN_W'(8);
         mid_message = 1'b1;
         if (!w.last)
            return;
         tail = '0;
      end else begin
         tail    = w.data_word & ((64'd1 << (8 * n)) - 64'd1);
         msg_len = msg_len + LEN_W'(n);
      end
      tail[WORD_W-1 -: LEN_W] = msg_len;
      lane_a        = sip_compress(lane_a, tail);
      lane_b        = sip_compress(lane_b, tail);
      d.digest_low  = sip_finish(lane_a);
      d.digest_high = sip_finish(lane_b);
      digest_queue.push_back(d);
      reload_lanes();
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] digest mismatch: %s", $time, what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         key_a_lo = KEY_A_LOW_RST;
         key_a_hi = KEY_A_HIGH_RST;
         key_b_lo = KEY_B_LOW_RST;
         key_b_hi = KEY_B_HIGH_RST;
         reload_lanes();
         digest_queue.delete();
      end else begin
         // compare popped digests first: nothing accepted at this edge can be out yet
         if (!rsp_empty && rsp_pop) begin
            if (digest_queue.size() == 0) begin
               report_mismatch($sformatf("digest %h popped with none expected", rsp_word));
            end else begin
               head = digest_queue.pop_front();
               if (rsp_word.digest_low !== head.digest_low)
                  report_mismatch($sformatf("digest_low %h, expected %h",
                                            rsp_word.digest_low, head.digest_low));
               if (rsp_word.digest_high !== head.digest_high)
                  report_mismatch($sformatf("digest_high %h, expected %h",
                                            rsp_word.digest_high, head.digest_high));
               checked++;
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_KEY_A_LOW:  key_a_lo = csr_data;
               CSR_KEY_A_HIGH: key_a_hi = csr_data;
               CSR_KEY_B_LOW:  key_b_lo = csr_data;
               CSR_KEY_B_HIGH: key_b_hi = csr_data;
               default: ;
            endcase
            if (!mid_message)
               reload_lanes();
         end
         if (req_push && !req_full)
            absorb_word(req_word);
      end
      digests_pending <= digest_queue.size();
   end

endmodule

// ===== tb/sv/tb_dual_siphash_digest.sv =====
// Testbench top for dual_siphash_digest: clock, reset, key writes, message words,
// random idling on both sides and the final verdict.
// Depends on dsd_pkg, the block itself and dsd_digest_checker.
module tb_dual_siphash_digest;
   import dsd_pkg::*;

   localparam int LIMIT_CYCLES  = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_STALL    = 300;
   localparam int PHASE_WORDS   = 250;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   csr_index_type     csr_index = CSR_KEY_A_LOW;
   logic [WORD_W-1:0] csr_data = '0;
   logic              req_push = 1'b0;
   logic              req_full;
   req_type           req_word = '0;
   logic              rsp_empty;
   logic              rsp_pop = 1'b0;
   rsp_type           rsp_word;

   int fail_count;
   int digests_pending;
   int digests_checked;
   int words_sent = 0;
   int key_sets   = 0;
   int cycles     = 0;

   // handshakes between the word driver and the digest receiver
   bit stall_go     = 1'b0;
   bit stall_served = 1'b0;
   bit quiet_tail   = 1'b0;

   dual_siphash_digest u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_word  (req_word),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

   dsd_digest_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_word        (req_word),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_word        (rsp_word),
      .fail_count      (fail_count),
      .digests_pending (digests_pending),
      .digests_checked (digests_checked)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog: end the run if the stimulus or the drain hangs
   initial begin
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d digests still owed", cycles, digests_pending);
      $display("CHECKS FAILED");
      $finish;
   end

   // digest receiver: short random pop gaps, one long hold-off on request,
   // and a steady pop in the quiet tail of the run
   initial begin
      @(posedge clock);
      forever begin
         if (stall_go && !stall_served) begin
            rsp_pop <= 1'b0;
            repeat (LONG_STALL) @(posedge clock);
            stall_served <= 1'b1;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_pop <= 1'b1;
            @(posedge clock);
         end
      end
   end

   function automatic logic [WORD_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic req_type make_word(input logic [WORD_W-1:0] data,
                                         input logic [BYTES_W-1:0] count,
                                         input logic last);
      req_type w;
      w.data_word  = data;
      w.byte_count = count;
      w.last       = last;
      return w;
   endfunction

   // offer one word, maybe after a short gap, and hold it until the block takes it;
   // push stays high on return so back-to-back words need no extra edge
   task automatic send_word(input req_type w);
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_word <= w;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      words_sent++;
   endtask

   // one well-formed message: a body of full words, then a word that ends it
   task automatic send_message(input bit short_only);
      int unsigned      body;
      logic [BYTES_W-1:0] count;
      if (short_only)
         body = 0;
      else if ($urandom_range(0, 24) == 0)
         body = $urandom_range(30, 40);   // 240 to 320 body bytes: from 32 words on the length byte wraps
      else
         body = $urandom_range(0, 4);
      repeat (body) begin
         count = ($urandom_range(0, 9) == 0) ? BYTES_W'($urandom_range(9, 15)) : FULL_BYTES;
         send_word(make_word(rand64(), count, 1'b0));
      end
      if (!short_only && $urandom_range(0, 3) == 0) begin
         // close on a full word flagged last; oversize counts act as full
         count = $urandom_range(0, 1) ? FULL_BYTES : BYTES_W'($urandom_range(9, 15));
         send_word(make_word(rand64(), count, 1'b1));
      end else begin
         // a short word closes the message whatever its last flag says
         send_word(make_word(rand64(), BYTES_W'($urandom_range(0, 7)), 1'($urandom)));
      end
   endtask

   // drop push and wait for every owed digest, then let the pipeline settle
   task automatic flush_digests();
      req_push <= 1'b0;
      @(posedge clock);
      while (digests_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_key(input csr_index_type idx, input logic [WORD_W-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // write all four key registers while the block is idle
   task automatic load_keys(input logic [WORD_W-1:0] a_lo, input logic [WORD_W-1:0] a_hi,
                            input logic [WORD_W-1:0] b_lo, input logic [WORD_W-1:0] b_hi);
      put_key(CSR_KEY_A_LOW, a_lo);
      put_key(CSR_KEY_A_HIGH, a_hi);
      put_key(CSR_KEY_B_LOW, b_lo);
      put_key(CSR_KEY_B_HIGH, b_hi);
      csr_valid <= 1'b0;
      key_sets++;
   endtask

   initial begin
      int target;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed words under the reset keys
      // empty messages closed by a bare short word, with and without last
      send_word(make_word('1, 4'd0, 1'b0));
      send_word(make_word('0, 4'd0, 1'b1));
      // full word flagged last: the tail carries only the length byte
      send_word(make_word('1, FULL_BYTES, 1'b1));
      // short word without last ends the message; junk above the count is dropped
      send_word(make_word('0, FULL_BYTES, 1'b0));
      send_word(make_word('1, 4'd7, 1'b0));
      // oversize counts act as full words
      send_word(make_word('1, 4'd15, 1'b0));
      send_word(make_word(64'h0123456789abcdef, 4'd9, 1'b1));
      // the other short counts, 1 to 6
      send_word(make_word('1, 4'd1, 1'b1));
      send_word(make_word('1, 4'd2, 1'b0));
      send_word(make_word('1, 4'd3, 1'b1));
      send_word(make_word('1, 4'd4, 1'b0));
      send_word(make_word('1, 4'd5, 1'b1));
      send_word(make_word('1, 4'd6, 1'b0));
      // multi-word message ending on a partial word
      send_word(make_word(64'h0706050403020100, FULL_BYTES, 1'b0));
      send_word(make_word(64'hffffffffffffffff, FULL_BYTES, 1'b0));
      send_word(make_word(64'h000e0d0c0b0a0908, 4'd7, 1'b1));
      send_word(make_word(rand64(), 4'd3, 1'b1));
      flush_digests();

      // random phases, each under its own key setting
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: load_keys('0, '0, '0, '0);
            1: load_keys('1, '1, '1, '1);
            4: load_keys(KEY_A_LOW_RST, KEY_A_HIGH_RST, KEY_B_LOW_RST, KEY_B_HIGH_RST);
            default: load_keys(rand64(), rand64(), rand64(), rand64());
         endcase
         if (phase == 2) begin
            // hold the receiver off and offer 60 short messages, enough to back up the input
            stall_go <= 1'b1;
            repeat (60) send_message(1'b1);
         end
         if (phase == 5)
            quiet_tail <= 1'b1;
         target = words_sent + PHASE_WORDS;
         while (words_sent < target)
            send_message(1'b0);
         flush_digests();
      end

      $display("run covered %0d message words and %0d digests over %0d key settings,",
               words_sent, digests_checked, key_sets);
      $display("with a long digest stall that backed up the input and a gap-free tail");
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
